### rtl/fesk_pkg.sv
// Shared types, constants and the bucket hash of the flow key set.
package fesk_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int PTR_W    = IDX_W + 1;
  localparam int KEY_W    = 48;
  localparam int IP_W     = 32;
  localparam int PORT_W   = 16;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [KEY_W-1:0] key_t;

  // empty marker doubles as the full count
  localparam ptr_t EMPTY    = PTR_W'(CAPACITY);
  localparam ptr_t FULL_CNT = PTR_W'(CAPACITY);

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUCKET,
    ST_WALK,
    ST_CHECK,
    ST_DECIDE,
    ST_EV_HASH,
    ST_UNLINK_RD,
    ST_UNLINK_WR,
    ST_FREE_PUSH,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_AGE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic was_present;
    logic evicted_oldest;
  } res_t;

  // xor fold of the key down to a bucket index
  function automatic idx_t bucket_of(key_t k);
    idx_t h;
    h = '0;
    for (int i = 0; i < KEY_W; i += IDX_W) begin
      h ^= IDX_W'(k >> i);
    end
    return h;
  endfunction

endpackage

### rtl/fesk_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
module fesk_ram #(
  parameter int Depth = 1024,
  parameter int Width = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/fesk_engine.sv
// Lookup, insert, remove and evict sequencer over the key, chain and age memories.
module fesk_engine
  import fesk_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        func,
  input  logic [IP_W-1:0]   ip_address,
  input  logic [PORT_W-1:0] port_number,
  output logic              res_valid,
  input  logic              res_stall,
  output res_t              res
);

  state_t state, state_next;

  // control
  ptr_t count, oldest, newest, fresh, free_head, clr;
  // per-item payload
  logic [1:0] func_q;
  key_t       key_q;
  idx_t       bkt;
  ptr_t       cur, prev, target;
  logic       present, evict, popped;

  // memory ports
  logic key_we, bkt_we, lnk_we, nwr_we, old_we;
  idx_t key_wa, bkt_wa, lnk_wa, nwr_wa, old_wa;
  idx_t key_ra, bkt_ra, lnk_ra, nwr_ra, old_ra;
  key_t key_wd, key_rd;
  ptr_t bkt_wd, lnk_wd, nwr_wd, old_wd;
  ptr_t bkt_rd, lnk_rd, nwr_rd, old_rd;

  idx_t hb;
  assign hb = bucket_of(key_q);

  fesk_ram #(.Depth(CAPACITY), .Width(KEY_W)) u_key (
    .clk, .we(key_we), .waddr(key_wa), .wdata(key_wd), .raddr(key_ra), .rdata(key_rd));
  fesk_ram #(.Depth(CAPACITY), .Width(PTR_W)) u_bkt (
    .clk, .we(bkt_we), .waddr(bkt_wa), .wdata(bkt_wd), .raddr(bkt_ra), .rdata(bkt_rd));
  fesk_ram #(.Depth(CAPACITY), .Width(PTR_W)) u_lnk (
    .clk, .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd), .raddr(lnk_ra), .rdata(lnk_rd));
  fesk_ram #(.Depth(CAPACITY), .Width(PTR_W)) u_nwr (
    .clk, .we(nwr_we), .waddr(nwr_wa), .wdata(nwr_wd), .raddr(nwr_ra), .rdata(nwr_rd));
  fesk_ram #(.Depth(CAPACITY), .Width(PTR_W)) u_old (
    .clk, .we(old_we), .waddr(old_wa), .wdata(old_wd), .raddr(old_ra), .rdata(old_rd));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:     if (clr == PTR_W'(CAPACITY - 1)) state_next = ST_IDLE;
      ST_IDLE:      if (in_valid) state_next = ST_BUCKET;
      ST_BUCKET:    state_next = ST_WALK;
      ST_WALK: begin
        if (cur == EMPTY) state_next = evict ? ST_UNLINK_RD : ST_DECIDE;
        else if (evict && cur == target) state_next = ST_UNLINK_RD;
        else state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!evict && key_rd == key_q) state_next = ST_DECIDE;
        else state_next = ST_WALK;
      end
      ST_DECIDE: begin
        if (func_q == FUNC_REMOVE && present) state_next = ST_UNLINK_RD;
        else if (func_q == FUNC_ADD && !present)
          state_next = (count == FULL_CNT) ? ST_EV_HASH : ST_INS_RD;
        else state_next = ST_DONE;
      end
      ST_EV_HASH:   state_next = ST_BUCKET;
      ST_UNLINK_RD: state_next = ST_UNLINK_WR;
      ST_UNLINK_WR: state_next = evict ? ST_INS_RD : ST_FREE_PUSH;
      ST_FREE_PUSH: state_next = ST_DONE;
      ST_INS_RD:    state_next = ST_INS_WR;
      ST_INS_WR:    state_next = ST_INS_AGE;
      ST_INS_AGE:   state_next = ST_DONE;
      ST_DONE:      if (!res_stall) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // memory controls and handshake
  always_comb begin
    key_we = 1'b0; key_wa = '0; key_wd = '0; key_ra = '0;
    bkt_we = 1'b0; bkt_wa = '0; bkt_wd = '0; bkt_ra = '0;
    lnk_we = 1'b0; lnk_wa = '0; lnk_wd = '0; lnk_ra = '0;
    nwr_we = 1'b0; nwr_wa = '0; nwr_wd = '0; nwr_ra = '0;
    old_we = 1'b0; old_wa = '0; old_wd = '0; old_ra = '0;
    in_stall  = (state != ST_IDLE);
    res_valid = (state == ST_DONE);
    case (state)
      ST_CLEAR: begin
        bkt_we = 1'b1; bkt_wa = clr[IDX_W-1:0]; bkt_wd = EMPTY;
      end
      ST_IDLE:    bkt_ra = bucket_of({port_number, ip_address});
      ST_WALK: begin
        key_ra = cur[IDX_W-1:0];
        lnk_ra = cur[IDX_W-1:0];
      end
      ST_DECIDE:  key_ra = oldest[IDX_W-1:0];
      ST_EV_HASH: bkt_ra = bucket_of(key_rd);
      ST_UNLINK_RD: begin
        lnk_ra = target[IDX_W-1:0];
        nwr_ra = target[IDX_W-1:0];
        old_ra = target[IDX_W-1:0];
      end
      ST_UNLINK_WR: begin
        if (prev != EMPTY) begin
          lnk_we = 1'b1; lnk_wa = prev[IDX_W-1:0]; lnk_wd = lnk_rd;
        end else begin
          bkt_we = 1'b1; bkt_wa = bkt; bkt_wd = lnk_rd;
        end
        if (old_rd != EMPTY) begin
          nwr_we = 1'b1; nwr_wa = old_rd[IDX_W-1:0]; nwr_wd = nwr_rd;
        end
        if (nwr_rd != EMPTY) begin
          old_we = 1'b1; old_wa = nwr_rd[IDX_W-1:0]; old_wd = old_rd;
        end
      end
      ST_FREE_PUSH: begin
        lnk_we = 1'b1; lnk_wa = target[IDX_W-1:0]; lnk_wd = free_head;
      end
      ST_INS_RD: begin
        bkt_ra = hb;
        lnk_ra = free_head[IDX_W-1:0];
      end
      ST_INS_WR: begin
        key_we = 1'b1; key_wa = target[IDX_W-1:0]; key_wd = key_q;
        lnk_we = 1'b1; lnk_wa = target[IDX_W-1:0]; lnk_wd = bkt_rd;
        bkt_we = 1'b1; bkt_wa = hb;                bkt_wd = target;
        old_we = 1'b1; old_wa = target[IDX_W-1:0]; old_wd = newest;
        nwr_we = 1'b1; nwr_wa = target[IDX_W-1:0]; nwr_wd = EMPTY;
      end
      ST_INS_AGE: begin
        if (newest != EMPTY) begin
          nwr_we = 1'b1; nwr_wa = newest[IDX_W-1:0]; nwr_wd = target;
        end
      end
      default: ;
    endcase
  end

  assign res.was_present    = present;
  assign res.evicted_oldest = evict;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      count     <= '0;
      oldest    <= EMPTY;
      newest    <= EMPTY;
      fresh     <= '0;
      free_head <= EMPTY;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: clr <= clr + 1'b1;
        ST_UNLINK_WR: begin
          if (old_rd == EMPTY) oldest <= nwr_rd;
          if (nwr_rd == EMPTY) newest <= old_rd;
          count <= count - 1'b1;
        end
        ST_FREE_PUSH: free_head <= target;
        ST_INS_RD: begin
          if (!evict && free_head == EMPTY) fresh <= fresh + 1'b1;
        end
        ST_INS_WR: if (popped) free_head <= lnk_rd;
        ST_INS_AGE: begin
          if (newest == EMPTY) oldest <= target;
          newest <= target;
          count  <= count + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // per-item payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        func_q  <= func;
        key_q   <= {port_number, ip_address};
        bkt     <= bucket_of({port_number, ip_address});
        present <= 1'b0;
        evict   <= 1'b0;
      end
      ST_BUCKET: begin
        cur  <= bkt_rd;
        prev <= EMPTY;
      end
      ST_CHECK: begin
        if (!evict && key_rd == key_q) begin
          present <= 1'b1;
          target  <= cur;
        end else begin
          prev <= cur;
          cur  <= lnk_rd;
        end
      end
      ST_DECIDE: begin
        if (func_q == FUNC_ADD && !present && count == FULL_CNT) begin
          evict  <= 1'b1;
          target <= oldest;
        end
      end
      ST_EV_HASH: bkt <= bucket_of(key_rd);
      ST_INS_RD: begin
        if (evict) begin
          popped <= 1'b0;
        end else if (free_head != EMPTY) begin
          target <= free_head;
          popped <= 1'b1;
        end else begin
          target <= fresh;
          popped <= 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/fifo_evicting_flow_key_set.sv
// Query walks the bucket chain of the key; add and remove also unlink or link slots,
// and eviction adds a walk of the evicted key's chain.
// Throughput: one item at a time; no new item is taken until the last result has left the
// engine. The time per item grows with the chain walk in the key and link memories.
// Reset: synchronous, active high; after reset the bucket heads are swept to empty, during
// which in_stall stays high.
module fifo_evicting_flow_key_set
  import fesk_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        func,
  input  logic [IP_W-1:0]   ip_address,
  input  logic [PORT_W-1:0] port_number,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              was_present,
  output logic              evicted_oldest
);

  logic res_valid, res_stall;
  res_t res;

  // engine walks the hash chain, unlinks and links slots in the age list
  fesk_engine u_engine (
    .clk, .rst,
    .in_valid, .in_stall,
    .func, .ip_address, .port_number,
    .res_valid, .res_stall, .res
  );

  // output register: the engine finishes only into an empty or draining slot
  assign res_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && !res_stall) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && !res_stall) begin
      was_present    <= res.was_present;
      evicted_oldest <= res.evicted_oldest;
    end
  end

  // an eviction only happens on an add of an absent key
  a_evict_absent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(evicted_oldest && was_present))
    else $error("eviction reported for a present key");

  // once an item is taken the engine is busy the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("engine took a beat while still working");

  // a result beat always lands in the output register
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall) |=> out_valid)
    else $error("result beat lost");

endmodule
